### design/rotary_encoder_command_decoder_macros.svh
// ----------------------------------------------------------------------------
// rotary encoder command decoder assertion macros
// concurrent assertion helpers clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_COMMAND_DECODER_MACROS_SVH
`define ROTARY_ENCODER_COMMAND_DECODER_MACROS_SVH

// property must hold at every edge out of reset
`define RECD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// expression must never be true out of reset
`define RECD_NEVER(label, expr, msg) \
    `RECD_ASSERT(label, !(expr), msg)

`endif

### design/recd_pkg.sv
// ----------------------------------------------------------------------------
// recd_pkg
// shared types, codes and the command mapping function
// ----------------------------------------------------------------------------
package recd_pkg;

    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 16;
    localparam int PosWidth      = 8;
    localparam int TimerWidth    = 16;
    localparam int CodeWidth     = 3;

    localparam logic [CfgIndexWidth-1:0] REG_LONGPRESS_ENABLE = 8'd0;
    localparam logic [CfgIndexWidth-1:0] REG_FIVE_BUTTONS     = 8'd1;
    localparam logic [CfgIndexWidth-1:0] REG_INVERT_VOLUME    = 8'd2;
    localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS_TICKS = 8'd3;

    localparam logic [TimerWidth-1:0] LONG_PRESS_TICKS_RESET = 16'd1000;
    localparam logic [TimerWidth-1:0] TIMER_MAX              = 16'hFFFF;

    localparam logic [CodeWidth-1:0] CODE_NONE      = 3'd0;
    localparam logic [CodeWidth-1:0] CODE_UP        = 3'd1;
    localparam logic [CodeWidth-1:0] CODE_DOWN      = 3'd2;
    localparam logic [CodeWidth-1:0] CODE_UP_LONG   = 3'd3;
    localparam logic [CodeWidth-1:0] CODE_DOWN_LONG = 3'd4;
    localparam logic [CodeWidth-1:0] CODE_FOUR      = 3'd5;
    localparam logic [CodeWidth-1:0] CODE_FIVE      = 3'd6;

    typedef enum logic [1:0] {
        CMD_NEXT  = 2'd0,
        CMD_PREV  = 2'd1,
        CMD_VUP   = 2'd2,
        CMD_VDOWN = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                  longpress_enable;
        logic                  five_buttons;
        logic                  invert_volume;
        logic [TimerWidth-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic clk_level;
        logic dt_level;
        logic poll;
    } item_t;

    function automatic logic [CodeWidth-1:0] map_code(input cmd_t cmd, input cfg_t cfg);
        logic [CodeWidth-1:0] code;
        code = CODE_NONE;
        case (cmd)
            CMD_NEXT: begin
                code = cfg.five_buttons ? CODE_UP
                     : (cfg.invert_volume ? CODE_UP_LONG : CODE_UP);
            end
            CMD_PREV: begin
                code = cfg.five_buttons ? CODE_DOWN
                     : (cfg.invert_volume ? CODE_DOWN_LONG : CODE_DOWN);
            end
            CMD_VUP: begin
                code = cfg.five_buttons ? CODE_FOUR
                     : (cfg.invert_volume ? CODE_UP : CODE_UP_LONG);
            end
            CMD_VDOWN: begin
                code = cfg.five_buttons ? CODE_FIVE
                     : (cfg.invert_volume ? CODE_DOWN : CODE_DOWN_LONG);
            end
            default: begin
                code = CODE_NONE;
            end
        endcase
        return code;
    endfunction

endpackage

### design/recd_cfg_regs.sv
// ----------------------------------------------------------------------------
// recd_cfg_regs
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
module recd_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [recd_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [recd_pkg::CfgDataWidth-1:0]    cfg_data,
    output recd_pkg::cfg_t                       cfg
);

    recd_pkg::cfg_t cfg_reg;
    recd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                recd_pkg::REG_LONGPRESS_ENABLE: cfg_next.longpress_enable = cfg_data[0];
                recd_pkg::REG_FIVE_BUTTONS:     cfg_next.five_buttons     = cfg_data[0];
                recd_pkg::REG_INVERT_VOLUME:    cfg_next.invert_volume    = cfg_data[0];
                recd_pkg::REG_LONG_PRESS_TICKS: begin
                    cfg_next.long_press_ticks = cfg_data[recd_pkg::TimerWidth-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.longpress_enable <= 1'b1;
            cfg_reg.five_buttons     <= 1'b0;
            cfg_reg.invert_volume    <= 1'b0;
            cfg_reg.long_press_ticks <= recd_pkg::LONG_PRESS_TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/recd_core.sv
// ----------------------------------------------------------------------------
// recd_core
// edge counting, timers and command decision for one tick per transaction
// ----------------------------------------------------------------------------
`include "rotary_encoder_command_decoder_macros.svh"

module recd_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  recd_pkg::item_t                   item,
    input  recd_pkg::cfg_t                    cfg,
    output logic [recd_pkg::CodeWidth-1:0]    code
);

    logic                              last_clk_reg;
    logic                              last_clk_next;
    logic [recd_pkg::PosWidth-1:0]     position_reg;
    logic [recd_pkg::PosWidth-1:0]     position_next;
    logic                              vol_active_reg;
    logic                              vol_active_next;
    logic [recd_pkg::TimerWidth-1:0]   vol_elapsed_reg;
    logic [recd_pkg::TimerWidth-1:0]   vol_elapsed_next;
    logic                              hold_active_reg;
    logic                              hold_active_next;
    logic [recd_pkg::TimerWidth-1:0]   hold_elapsed_reg;
    logic [recd_pkg::TimerWidth-1:0]   hold_elapsed_next;

    logic [recd_pkg::PosWidth-1:0]     pos_moved;
    logic                              pos_zero;
    logic                              pos_neg;
    logic                              pos_big;
    logic                              vol_running;
    logic                              hold_expired;
    logic                              vol_act_mid;
    logic [recd_pkg::TimerWidth-1:0]   vol_el_mid;
    logic                              hold_act_mid;
    logic [recd_pkg::TimerWidth-1:0]   hold_el_mid;

    always_comb begin
        pos_moved = position_reg;
        if (last_clk_reg && !item.clk_level) begin
            pos_moved = item.dt_level ? position_reg + 8'd1 : position_reg - 8'd1;
        end
        pos_zero     = (pos_moved == '0);
        pos_neg      = pos_moved[recd_pkg::PosWidth-1];
        // magnitude above one detent
        pos_big      = !pos_zero && (pos_moved != 8'h01) && (pos_moved != 8'hFF);
        vol_running  = vol_active_reg && (vol_elapsed_reg < cfg.long_press_ticks);
        hold_expired = hold_elapsed_reg >= cfg.long_press_ticks;

        code         = recd_pkg::CODE_NONE;
        vol_act_mid  = vol_active_reg;
        vol_el_mid   = vol_elapsed_reg;
        hold_act_mid = hold_active_reg;
        hold_el_mid  = hold_elapsed_reg;

        if (item.poll && !pos_zero) begin
            if (!cfg.longpress_enable) begin
                code = recd_pkg::map_code(pos_neg ? recd_pkg::CMD_VDOWN : recd_pkg::CMD_VUP, cfg);
            end else if (pos_big || vol_running) begin
                code         = recd_pkg::map_code(pos_neg ? recd_pkg::CMD_VDOWN
                                                          : recd_pkg::CMD_VUP, cfg);
                vol_act_mid  = 1'b1;
                vol_el_mid   = '0;
                hold_act_mid = 1'b0;
            end else if (!hold_active_reg) begin
                hold_act_mid = 1'b1;
                hold_el_mid  = '0;
            end else if (hold_expired) begin
                code = recd_pkg::map_code(pos_neg ? recd_pkg::CMD_PREV : recd_pkg::CMD_NEXT, cfg);
            end
        end

        last_clk_next     = item.clk_level;
        position_next     = (code != recd_pkg::CODE_NONE) ? '0 : pos_moved;
        vol_active_next   = vol_act_mid;
        hold_active_next  = hold_act_mid;
        vol_elapsed_next  = (vol_act_mid && vol_el_mid != recd_pkg::TIMER_MAX)
                          ? vol_el_mid + 16'd1 : vol_el_mid;
        hold_elapsed_next = (hold_act_mid && hold_el_mid != recd_pkg::TIMER_MAX)
                          ? hold_el_mid + 16'd1 : hold_el_mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_clk_reg     <= 1'b0;
            position_reg     <= '0;
            vol_active_reg   <= 1'b0;
            vol_elapsed_reg  <= '0;
            hold_active_reg  <= 1'b0;
            hold_elapsed_reg <= '0;
        end else if (advance) begin
            last_clk_reg     <= last_clk_next;
            position_reg     <= position_next;
            vol_active_reg   <= vol_active_next;
            vol_elapsed_reg  <= vol_elapsed_next;
            hold_active_reg  <= hold_active_next;
            hold_elapsed_reg <= hold_elapsed_next;
        end
    end

    // volume timer is never stopped once started
    `RECD_ASSERT(a_vol_sticky, vol_active_reg |=> vol_active_reg, "volume timer stopped")
    // an emitted command clears the position
    `RECD_ASSERT(a_pos_clear, (advance && code != recd_pkg::CODE_NONE) |=> position_reg == '0,
                 "position kept after command")

endmodule

### design/rotary_encoder_command_decoder.sv
// ----------------------------------------------------------------------------
// rotary_encoder_command_decoder
// quadrature decoder turning sampled encoder ticks into command codes
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// s_       in         s_valid / s_ready   s_clk_level, s_dt_level, s_poll
// m_       out        m_valid / m_ready   m_command_code
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one transaction per cycle sustained while m_ready stays high; an accepted tick passes
// through the input register, then decision logic into the result register
// decoder state advances only when a tick moves from input to result register
// a stalled result holds the input register; s_ready drops only while both are full
// synchronous active-low reset restores valid flags and decoder and config state
// ----------------------------------------------------------------------------
`include "rotary_encoder_command_decoder_macros.svh"

module rotary_encoder_command_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_clk_level,
    input  logic                                 s_dt_level,
    input  logic                                 s_poll,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [recd_pkg::CodeWidth-1:0]       m_command_code,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [recd_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [recd_pkg::CfgDataWidth-1:0]    cfg_data
);

    recd_pkg::cfg_t                      cfg;
    recd_pkg::item_t                     item_reg;
    logic                                in_valid_reg;
    logic                                out_valid_reg;
    logic [recd_pkg::CodeWidth-1:0]      code_reg;
    logic [recd_pkg::CodeWidth-1:0]      code_next;
    logic                                advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign m_valid        = out_valid_reg;
    assign m_command_code = code_reg;

    recd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    recd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .code    (code_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.clk_level <= s_clk_level;
            item_reg.dt_level  <= s_dt_level;
            item_reg.poll      <= s_poll;
        end
        if (advance) begin
            code_reg <= code_next;
        end
    end

    `RECD_NEVER(a_code_range, out_valid_reg && code_reg > recd_pkg::CODE_FIVE,
                "command code out of range")
    `RECD_NEVER(a_full_stall, in_valid_reg && out_valid_reg && !m_ready && s_ready,
                "ready high with both stages full")
    `RECD_ASSERT(a_advance_out, advance |=> out_valid_reg, "advanced tick lost")

endmodule
